### hw/rtl/lru_key_value_cache_unit_defines.svh
// ---------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms used by the cache RTL.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUKV_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRUKV_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lrukv_pkg.sv
// ---------------------------------------------------------------------------
// LRU key-value cache package
// Opcodes, field widths and constants shared by the cache modules.
// ---------------------------------------------------------------------------
package lrukv_pkg;

  localparam int unsigned KEY_W     = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_e;

  // Outcome of the lookup for the item at the head of the pipeline.
  typedef struct packed {
    logic hit;    // key present in a valid entry
    logic fill;   // miss, a free entry will be taken
    logic evict;  // miss, the least recent entry will be replaced
  } lookup_t;

endpackage

### hw/rtl/lrukv_store.sv
// ---------------------------------------------------------------------------
// LRU key-value cache tag and recency store
// Holds keys, valid bits and recency ranks; does the parallel key compare
// and picks the entry that an item touches or fills.
// ---------------------------------------------------------------------------
`include "lru_key_value_cache_unit_defines.svh"

module lrukv_store #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [lrukv_pkg::CAP_W-1:0]            cap_i,
  input  logic                                   upd_i,
  input  lrukv_pkg::opcode_e                     op_i,
  input  logic [KEY_BITS-1:0]                    key_i,
  output lrukv_pkg::lookup_t                     look_o,
  output logic [$clog2((ENTRIES > 1) ? ENTRIES : 2)-1:0] slot_o
);
  import lrukv_pkg::*;

  localparam int unsigned IW = $clog2((ENTRIES > 1) ? ENTRIES : 2);
  localparam int unsigned OW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (OW > CAP_W) ? OW : CAP_W;

  logic [KEY_BITS-1:0] key_q  [ENTRIES];
  logic [IW-1:0]       rank_q [ENTRIES];
  logic [IW-1:0]       rank_d [ENTRIES];
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [OW-1:0]       occ_q, occ_d;

  logic [ENTRIES-1:0]  match, free_oh, victim_oh, slot_oh;
  logic [IW-1:0]       hit_rank, ref_rank, victim_rank, slot_idx;
  logic [CW-1:0]       eff_cap;
  logic                hit, room, commit, grow;

  // Parallel compare and rank lookups over all entries.
  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = valid_q[i] && (key_q[i] == key_i);
      victim_oh[i] = valid_q[i] && (rank_q[i] == victim_rank);
      if (match[i]) begin
        hit_rank = hit_rank | rank_q[i];
      end
    end
  end

  // Valid ranks always form 0..occ-1, so the least recent entry holds occ-1.
  assign victim_rank = IW'(occ_q - 1'b1);
  // Lowest-index free entry: lowest zero of the valid vector.
  assign free_oh     = ~valid_q & (valid_q + ENTRIES'(1));
  assign hit         = |match;

  always_comb begin
    if (cap_i == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_i) > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = CW'(cap_i);
    end
  end

  assign room     = CW'(occ_q) < eff_cap;
  assign slot_oh  = hit ? match : (room ? free_oh : victim_oh);
  assign ref_rank = hit ? hit_rank : victim_rank;

  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_oh[i]) begin
        slot_idx = slot_idx | IW'(i);
      end
    end
  end

  assign slot_o       = slot_idx;
  assign look_o.hit   = hit;
  assign look_o.fill  = !hit && room;
  assign look_o.evict = !hit && !room;

  // A get miss leaves the state alone; everything else touches one entry.
  assign commit = upd_i && ((op_i == OP_PUT) || hit);
  assign grow   = commit && look_o.fill;

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q + OW'(grow);
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (commit) begin
        if (slot_oh[i]) begin
          rank_d[i]  = '0;
          valid_d[i] = 1'b1;
        end else if (valid_q[i] && (grow || (rank_q[i] < ref_rank))) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (commit && !hit && slot_oh[i]) begin
        key_q[i] <= key_i;
      end
    end
  end

  `LRUKV_ASSERT_IMPL(a_occ_matches_valid, clk_i, rst_ni, 1'b1, $countones(valid_q) == occ_q, "occupancy count disagrees with valid bits")
  `LRUKV_ASSERT_IMPL(a_unique_match, clk_i, rst_ni, 1'b1, $onehot0(match), "key found in more than one entry")
  `LRUKV_ASSERT_IMPL(a_victim_found, clk_i, rst_ni, commit && look_o.evict, $onehot(victim_oh), "no unique least recent entry on eviction")
  `LRUKV_ASSERT_NEXT(a_fill_grows, clk_i, rst_ni, grow, occ_q == ($past(occ_q) + 1'b1), "fill did not raise occupancy")

endmodule

### hw/rtl/lru_key_value_cache_unit.sv
// ---------------------------------------------------------------------------
// LRU key-value cache unit
// Fully associative key-value store with least-recently-used replacement.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  --------  ---------  --------------------------------------------------
//  s_axis    in         tuser: opcode (get/put); tdata: key, value
//  m_axis    out        tuser: hit; tdata: read_value (all ones on a miss)
//  cfg       in         capacity, written when cfg_we_i is high
//
// Each beat is held in the input register; the tag compare, the recency
// update and the value memory access all happen on the edge that moves
// it on, so the unit sustains one beat per cycle unless a get stalls. The
// limit is the single compare-and-update pass over the entry registers.
// A put never produces a result beat and never waits. A get waits in the
// input register only while the result register is full and not taken.
// Reset clears valid bits, ranks and occupancy at once; there is no
// clearing pass, so the unit is ready in the first cycle after reset.
//
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: capacity register
  input  logic                                cfg_we_i,
  input  logic [lrukv_pkg::CAP_W-1:0]         cfg_wdata_i,
  // Request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [47:0]                         s_axis_tdata,   // [15:0] key, [47:16] value
  input  logic                                s_axis_tuser,   // [0] opcode
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lrukv_pkg::VALUE_W-1:0]       m_axis_tdata,   // [31:0] read_value
  output logic                                m_axis_tuser    // [0] hit
);
  import lrukv_pkg::*;

  localparam int unsigned IW = $clog2((ENTRIES > 1) ? ENTRIES : 2);

  // Capacity register.
  logic [CAP_W-1:0]   cap_q;

  // Input register.
  logic               inq_valid_q;
  opcode_e            inq_op_q;
  logic [KEY_W-1:0]   inq_key_q;
  logic [VALUE_W-1:0] inq_val_q;

  // Result register; the read data register doubles as the memory read port.
  logic               res_valid_q;
  logic               res_hit_q;
  logic [VALUE_W-1:0] rdata_q;

  // Value store, one word per entry.
  logic [VALUE_W-1:0] val_mem [ENTRIES];

  lookup_t            look;
  logic [IW-1:0]      slot;
  logic               advance, take_in, is_get;

  assign is_get  = (inq_op_q == OP_GET);
  // The head item moves on unless it is a get and the result register is
  // still holding a beat that the sink has not taken.
  assign advance = inq_valid_q && (!is_get || !res_valid_q || m_axis_tready);
  assign s_axis_tready = !inq_valid_q || advance;
  assign take_in = s_axis_tvalid && s_axis_tready;

  lrukv_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cap_i  (cap_q),
    .upd_i  (advance),
    .op_i   (inq_op_q),
    .key_i  (KEY_BITS'(inq_key_q)),
    .look_o (look),
    .slot_o (slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      inq_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (take_in) begin
        inq_valid_q <= 1'b1;
      end else if (advance) begin
        inq_valid_q <= 1'b0;
      end
      if (advance && is_get) begin
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      inq_op_q  <= opcode_e'(s_axis_tuser);
      inq_key_q <= s_axis_tdata[KEY_W-1:0];
      inq_val_q <= s_axis_tdata[KEY_W +: VALUE_W];
    end
    if (advance && is_get) begin
      res_hit_q <= look.hit;
    end
  end

  // A put writes its value into the hit or chosen entry; a get reads the
  // hit entry. Only one of the two happens for a given item.
  always_ff @(posedge clk_i) begin
    if (advance && !is_get) begin
      val_mem[slot] <= inq_val_q;
    end
    if (advance && is_get) begin
      rdata_q <= val_mem[slot];
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tuser  = res_hit_q;
  assign m_axis_tdata  = res_hit_q ? rdata_q : MISS_VALUE;

endmodule

### verif/lru_key_value_cache_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU key-value cache unit testbench
// Streams get and put beats into the cache and checks every result beat
// against a shadow copy of the cache kept inside the bench, under several
// capacity settings and idle patterns on both stream sides.
// ---------------------------------------------------------------------------
module lru_key_value_cache_unit_tb;
  import lrukv_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One expected result beat: the hit flag and the value read back.
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
  } get_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata  = '0;    // [15:0] key, [47:16] value
  logic               s_axis_tuser  = 1'b0;  // [0] opcode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [VALUE_W-1:0] m_axis_tdata;          // [31:0] read_value
  logic               m_axis_tuser;          // [0] hit

  // Shadow copy of the cache contents, updated as each request beat is taken.
  logic [KEY_W-1:0]   shadow_key   [SLOTS];
  logic [VALUE_W-1:0] shadow_value [SLOTS];
  bit                 shadow_valid [SLOTS];
  int                 shadow_rank  [SLOTS];
  int                 shadow_count    = 0;
  logic [CAP_W-1:0]   shadow_capacity = CAP_RESET;

  // Results of get beats that have been accepted but not yet returned.
  get_result_t pending_reads[$];

  // Idle pattern of each side, in percent, and the long result-side hold-off.
  int src_idle_pct    = 0;
  int snk_stall_pct   = 0;
  int hold_off_cycles = 0;
  bit hold_off_active = 1'b0;

  int cycle_count    = 0;
  int mismatch_count = 0;
  int get_count      = 0;
  int hit_count      = 0;
  int put_count      = 0;
  int evict_count    = 0;
  int config_count   = 0;

  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  lru_key_value_cache_unit #(
    .ENTRIES (SLOTS),
    .KEY_BITS(KEY_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case the handshakes lock up.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_reads.size());
      $display("lru_key_value_cache_unit_tb NOT OK");
      $finish;
    end
  end

  // Long result-side hold-off, counted down once per cycle.
  always @(posedge clk_i) begin : hold_off_count
    if (hold_off_cycles > 0) begin
      hold_off_active <= 1'b1;
      hold_off_cycles--;
    end else begin
      hold_off_active <= 1'b0;
    end
  end

  // Move a valid entry to the front: every valid entry that was more recent
  // moves back by one place.
  function automatic void shadow_promote(int idx);
    int r;
    r = shadow_rank[idx];
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i] && i != idx && shadow_rank[i] < r) shadow_rank[i]++;
    end
    shadow_rank[idx] = 0;
  endfunction

  // Apply one accepted request beat to the shadow cache and queue the result
  // that a get must produce.
  function automatic void predict_lookup(opcode_e op, logic [KEY_W-1:0] key,
                                         logic [VALUE_W-1:0] value);
    int found;
    int slot;
    int worst;
    int limit;
    found = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_key[i] == key) found = i;
    end
    // A capacity of zero acts as one, anything above the entry count as full.
    limit = int'(shadow_capacity);
    if (limit == 0) limit = 1;
    if (limit > SLOTS) limit = SLOTS;

    if (op == OP_GET) begin
      get_count++;
      if (found >= 0) begin
        shadow_promote(found);
        pending_reads.push_back('{hit: 1'b1, value: shadow_value[found]});
        hit_count++;
      end else begin
        pending_reads.push_back('{hit: 1'b0, value: MISS_VALUE});
      end
      return;
    end

    put_count++;
    if (found >= 0) begin
      shadow_value[found] = value;
      shadow_promote(found);
      return;
    end

    if (shadow_count < limit) begin
      // Take the free entry with the lowest index; all others age by one.
      slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && !shadow_valid[i]) slot = i;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_valid[i]) shadow_rank[i]++;
      end
      shadow_valid[slot] = 1'b1;
      shadow_rank[slot]  = 0;
      shadow_count++;
    end else begin
      // Full, or capacity lowered below occupancy: replace the least recent.
      slot  = 0;
      worst = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_valid[i] && shadow_rank[i] > worst) begin
          worst = shadow_rank[i];
          slot  = i;
        end
      end
      shadow_promote(slot);
      evict_count++;
    end
    shadow_key[slot]   = key;
    shadow_value[slot] = value;
  endfunction

  task automatic note_mismatch(string what, logic [VALUE_W-1:0] want,
                               logic [VALUE_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at cycle %0d: %s expected %h, got %h", cycle_count, what,
               want, got);
    end
  endtask

  // Result side: checks each beat taken and drives tready. While a hold-off
  // is running the side refuses every beat so that the cache backs up.
  always @(posedge clk_i) begin : result_check
    get_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        note_mismatch("unrequested result beat, read_value", '0, m_axis_tdata);
      end else begin
        want = pending_reads.pop_front();
        if (m_axis_tuser !== want.hit) begin
          note_mismatch("hit", VALUE_W'(want.hit), VALUE_W'(m_axis_tuser));
        end
        if (m_axis_tdata !== want.value) note_mismatch("read_value", want.value, m_axis_tdata);
      end
    end
    if (hold_off_active) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Offer one request beat and wait until it is taken. The valid stays high
  // afterwards so that back-to-back beats follow without a gap; the next call
  // or a drain lowers it.
  task automatic send_beat(opcode_e op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {value, key};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_lookup(op, key, value);
  endtask

  // Stop sending and wait until every get has returned. A put gives no result
  // beat, so the task waits for the last one to leave the input register.
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    shadow_capacity = cap;
    config_count++;
    cfg_we_i <= 1'b0;
  endtask

  // Empty cache after reset, then the extremes of key and value, an update
  // of an existing key and a get of a key never stored.
  task automatic test_empty_cache_and_extremes();
    send_beat(OP_GET, 16'h0000, 32'h1234_5678);
    send_beat(OP_PUT, 16'h0000, 32'h8000_0000);
    send_beat(OP_PUT, 16'hFFFF, 32'h7FFF_FFFF);
    send_beat(OP_GET, 16'h0000, 32'hFFFF_FFFF);
    send_beat(OP_GET, 16'hFFFF, 32'h0000_0000);
    send_beat(OP_PUT, 16'hFFFF, 32'hFFFF_FFFF);
    send_beat(OP_GET, 16'hFFFF, 32'h0);
    send_beat(OP_GET, 16'h1234, 32'h0);
    send_beat(OP_PUT, 16'h5555, 32'h0000_0000);
    send_beat(OP_PUT, 16'hAAAA, 32'h0000_0001);
    send_beat(OP_GET, 16'hAAAA, 32'h0);
  endtask

  // Capacity zero acts as one and sits below the current occupancy, so a new
  // key must replace the least recent entry. Then a capacity above the entry
  // count opens the free entries again.
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_beat(OP_PUT, 16'h0F0F, 32'h0000_0007);
    send_beat(OP_GET, 16'h0000, 32'h0);
    send_beat(OP_GET, 16'h0F0F, 32'h0);
    send_beat(OP_PUT, 16'h0F0F, 32'h0000_0008);
    write_capacity(5'd31);
    send_beat(OP_PUT, 16'h00FF, 32'h0000_0009);
    send_beat(OP_GET, 16'h00FF, 32'h0);
    send_beat(OP_GET, 16'h5555, 32'h0);
  endtask

  // The result side holds off for a long stretch while the request side
  // keeps offering beats without a gap, so the cache must stall its input.
  task automatic test_input_backpressure();
    write_capacity(5'd16);
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    hold_off_cycles = 150;
    for (int i = 0; i < 12; i++) begin
      send_beat(OP_PUT, 16'(16'h0100 + i), $urandom);
    end
    for (int i = 0; i < 16; i++) begin
      send_beat(OP_GET, 16'(16'h0100 + (i % 14)), $urandom);
    end
    settle_idle();
  endtask

  // Mostly gets and puts over a small pool of keys, sized to the capacity so
  // that hits, updates and replacements all occur, with some random keys.
  task automatic test_random_traffic(int beats, int src_pct, int snk_pct,
                                     logic [CAP_W-1:0] cap);
    int span;
    opcode_e op;
    logic [KEY_W-1:0] key;
    write_capacity(cap);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    span = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : int'(cap));
    span = (span + 4 > POOL_SIZE) ? POOL_SIZE : span + 4;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    for (int i = 0; i < beats; i++) begin
      op  = opcode_e'($urandom_range(0, 1));
      key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(0, span - 1)]
                                      : KEY_W'($urandom);
      send_beat(op, key, $urandom);
    end
    settle_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_cache_and_extremes();
    test_capacity_limits();
    test_input_backpressure();
    test_random_traffic(90, 0, 0, 5'd16);
    test_random_traffic(85, 70, 0, 5'd4);
    test_random_traffic(85, 0, 70, 5'd31);
    test_random_traffic(85, 35, 35, CAP_W'($urandom_range(1, 16)));

    settle_idle();
    repeat (10) @(posedge clk_i);

    $display("covered %0d gets (%0d hits), %0d puts, %0d replacements, %0d capacity writes",
             get_count, hit_count, put_count, evict_count, config_count);
    $display("idle patterns on both sides and a long result-side hold-off; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending_reads.size() == 0) begin
      $display("lru_key_value_cache_unit_tb OK");
    end else begin
      $display("lru_key_value_cache_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lrukv_pkg.sv
hw/rtl/lrukv_store.sv
hw/rtl/lru_key_value_cache_unit.sv
verif/lru_key_value_cache_unit_tb.sv
